/* rtl/can_periodic_tx_scheduler_macros.svh */
// Assertion macros used by the scheduler top level.
`ifndef CAN_PERIODIC_TX_SCHEDULER_MACROS_SVH
`define CAN_PERIODIC_TX_SCHEDULER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CPTS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Check that cons holds in the cycle after ante.
`define CPTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

/* rtl/cpts_pkg.sv */
// Shared types, codes and constants of the periodic transmit scheduler.
package cpts_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam int HANDLE_W = 8;
    localparam int ID_W     = 29;
    localparam int LEN_W    = 4;
    localparam int TIME_W   = 32;

    localparam logic [LEN_W-1:0] MAX_DLC = LEN_W'(8);

    // Operation codes of an input word
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result word kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_TX     = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_LEN,
        ST_FULL,
        ST_NOT_FOUND
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_TX,
        S_FIND,
        S_SHIFT,
        S_TICK,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        STEP_HOLD,
        STEP_INC,
        STEP_DEC,
        STEP_CLR
    } step_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_APPEND,
        WR_SHIFT,
        WR_STAMP
    } wr_sel_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_REQ,
        EMIT_ENTRY,
        EMIT_STATUS
    } emit_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     can_id;
        logic [LEN_W-1:0]    length;
        logic [TIME_W-1:0]   interval;
        logic [TIME_W-1:0]   last_time;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        step_t   idx_step;
        step_t   cnt_step;
        logic    set_status;
        status_t status_code;
        wr_sel_t wr_sel;
        emit_t   emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       len_bad;
        logic       ivl_zero;
        logic       full;
        logic       at_end;
        logic       match;
        logic       due;
        logic       out_free;
    } dp_stat_t;

endpackage

/* rtl/cpts_datapath.sv */
// Scheduler datapath: request latch, entry table, walk index and result register.
module cpts_datapath import cpts_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [1:0]          op,
    input  logic [HANDLE_W-1:0] handle,
    input  logic [ID_W-1:0]     can_id,
    input  logic [LEN_W-1:0]    length,
    input  logic [TIME_W-1:0]   send_period,
    input  logic [TIME_W-1:0]   now_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [1:0]          status,
    output logic [HANDLE_W-1:0] tx_handle,
    output logic [ID_W-1:0]     tx_id,
    output logic [LEN_W-1:0]    tx_length,
    output logic                last
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Latched request
    logic [1:0]          req_op_reg;
    logic [HANDLE_W-1:0] req_handle_reg;
    logic [ID_W-1:0]     req_id_reg;
    logic [LEN_W-1:0]    req_len_reg;
    logic [TIME_W-1:0]   req_ivl_reg;
    logic [TIME_W-1:0]   req_now_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    idx_prev;
    status_t             code_reg;

    entry_t              mem [TABLE_DEPTH];
    entry_t              rd_data_reg;
    entry_t              wr_data;
    logic [IDX_W-1:0]    wr_addr;
    logic                wr_en;
    logic [TIME_W-1:0]   elapsed;

    logic                out_valid_reg, out_valid_next;
    logic                kind_reg;
    logic [1:0]          status_reg;
    logic [HANDLE_W-1:0] tx_handle_reg;
    logic [ID_W-1:0]     tx_id_reg;
    logic [LEN_W-1:0]    tx_length_reg;
    logic                last_reg;

    always_ff @(posedge clk) begin
        if (cmd.load)
        begin
            req_op_reg     <= op;
            req_handle_reg <= handle;
            req_id_reg     <= can_id;
            req_len_reg    <= length;
            req_ivl_reg    <= send_period;
            req_now_reg    <= now_ms;
        end
    end

    always_comb
    begin
        case (cmd.idx_step)
            STEP_INC: idx_next = idx_reg + CNT_W'(1);
            STEP_DEC: idx_next = idx_reg - CNT_W'(1);
            STEP_CLR: idx_next = '0;
            default:  idx_next = idx_reg;
        endcase
        case (cmd.cnt_step)
            STEP_INC: count_next = count_reg + CNT_W'(1);
            STEP_DEC: count_next = count_reg - CNT_W'(1);
            STEP_CLR: count_next = '0;
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
            code_reg  <= ST_OK;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (cmd.set_status)
            begin
                code_reg <= cmd.status_code;
            end
        end
    end

    assign idx_prev = idx_reg - CNT_W'(1);

    // Table write port: append at the tail, move up during a remove, or restamp on a tick
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = rd_data_reg;
        case (cmd.wr_sel)
            WR_APPEND:
            begin
                wr_addr           = count_reg[IDX_W-1:0];
                wr_data.handle    = req_handle_reg;
                wr_data.can_id    = req_id_reg;
                wr_data.length    = req_len_reg;
                wr_data.interval  = req_ivl_reg;
                wr_data.last_time = req_now_reg;
            end
            WR_SHIFT:
            begin
                wr_addr = idx_prev[IDX_W-1:0];
            end
            WR_STAMP:
            begin
                wr_data.last_time = req_now_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Prefetch the entry that the index points at next cycle
    always_ff @(posedge clk) begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_next[IDX_W-1:0]];
    end

    assign elapsed = req_now_reg - rd_data_reg.last_time;

    always_comb
    begin
        stat.op       = req_op_reg;
        stat.len_bad  = req_len_reg > MAX_DLC;
        stat.ivl_zero = req_ivl_reg == '0;
        stat.full     = count_reg == CNT_W'(TABLE_DEPTH);
        stat.at_end   = idx_reg == count_reg;
        stat.match    = rd_data_reg.handle == req_handle_reg;
        stat.due      = (rd_data_reg.interval != '0) && (elapsed >= rd_data_reg.interval);
        stat.out_free = !out_valid_reg || out_ready;
    end

    // Result register
    always_comb
    begin
        if (cmd.emit != EMIT_NONE)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        case (cmd.emit)
            EMIT_REQ:
            begin
                kind_reg      <= KIND_TX;
                status_reg    <= ST_OK;
                tx_handle_reg <= req_handle_reg;
                tx_id_reg     <= req_id_reg;
                tx_length_reg <= req_len_reg;
                last_reg      <= 1'b0;
            end
            EMIT_ENTRY:
            begin
                kind_reg      <= KIND_TX;
                status_reg    <= ST_OK;
                tx_handle_reg <= rd_data_reg.handle;
                tx_id_reg     <= rd_data_reg.can_id;
                tx_length_reg <= rd_data_reg.length;
                last_reg      <= 1'b0;
            end
            EMIT_STATUS:
            begin
                kind_reg      <= KIND_STATUS;
                status_reg    <= code_reg;
                tx_handle_reg <= '0;
                tx_id_reg     <= '0;
                tx_length_reg <= '0;
                last_reg      <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign status    = status_reg;
    assign tx_handle = tx_handle_reg;
    assign tx_id     = tx_id_reg;
    assign tx_length = tx_length_reg;
    assign last      = last_reg;

endmodule

/* rtl/cpts_ctrl.sv */
// Scheduler controller: sequences add, remove and tick over the datapath.
module cpts_ctrl import cpts_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd.load        = 1'b0;
        cmd.idx_step    = STEP_HOLD;
        cmd.cnt_step    = STEP_HOLD;
        cmd.set_status  = 1'b0;
        cmd.status_code = ST_OK;
        cmd.wr_sel      = WR_NONE;
        cmd.emit        = EMIT_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.idx_step = STEP_CLR;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.set_status = 1'b1;
                case (stat.op)
                    OP_ADD:
                    begin
                        if (stat.len_bad)
                        begin
                            cmd.status_code = ST_BAD_LEN;
                            state_next      = S_DONE;
                        end
                        else if (stat.ivl_zero)
                        begin
                            state_next = S_ADD_TX;
                        end
                        else if (stat.full)
                        begin
                            cmd.status_code = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FIND;
                        end
                    end
                    OP_REMOVE: state_next = S_FIND;
                    OP_TICK:   state_next = S_TICK;
                    default:   state_next = S_DONE;
                endcase
            end
            S_ADD_TX:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = EMIT_REQ;
                    state_next = S_DONE;
                end
            end
            S_FIND:
            begin
                if (stat.at_end)
                begin
                    if (stat.op == OP_ADD)
                    begin
                        cmd.wr_sel   = WR_APPEND;
                        cmd.cnt_step = STEP_INC;
                    end
                    else
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else if (stat.match)
                begin
                    if (stat.op == OP_ADD)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.idx_step = STEP_INC;
                        state_next   = S_SHIFT;
                    end
                end
                else
                begin
                    cmd.idx_step = STEP_INC;
                end
            end
            S_SHIFT:
            begin
                if (stat.at_end)
                begin
                    cmd.cnt_step = STEP_DEC;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.wr_sel   = WR_SHIFT;
                    cmd.idx_step = STEP_INC;
                end
            end
            S_TICK:
            begin
                if (stat.at_end)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit   = EMIT_STATUS;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (stat.due)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit     = EMIT_ENTRY;
                        cmd.wr_sel   = WR_STAMP;
                        cmd.idx_step = STEP_INC;
                    end
                end
                else
                begin
                    cmd.idx_step = STEP_INC;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = EMIT_STATUS;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/can_periodic_tx_scheduler.sv */
// Top level of the periodic CAN transmit scheduler.
//
// Input channel (in_valid/in_ready) takes one word per operation: op selects
// add, remove or tick; handle, can_id, length, send_period and now_ms ride along.
// Output channel (out_valid/out_ready) returns result words: zero or more
// transmit requests (kind 1) followed by one status word (kind 0, last 1).
// One operation is in work at a time; in_ready is high only while idle.
// The table is walked one entry per cycle, while the receiver keeps up, through
// a prefetching memory with one write and one read port. A tick passes through
// accept, decode, one check per entry and an end check that also issues the
// status. Add and remove search the table the same way; a found remove stops its
// search at the match and then moves the later entries up one per cycle.
// An add with bad length or zero interval, or a full table, skips the walk.
// Reset clears the entry count, walk index, status code, controller and output
// valid; table contents are left as they are and are never read before written.
// A stalled receiver holds the walk on the entry being requested; the result
// register lets the next operation be accepted while the final status waits.
module can_periodic_tx_scheduler import cpts_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [HANDLE_W-1:0] handle,
    input  logic [ID_W-1:0]     can_id,
    input  logic [LEN_W-1:0]    length,
    input  logic [TIME_W-1:0]   send_period,
    input  logic [TIME_W-1:0]   now_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [1:0]          status,
    output logic [HANDLE_W-1:0] tx_handle,
    output logic [ID_W-1:0]     tx_id,
    output logic [LEN_W-1:0]    tx_length,
    output logic                last
);

`include "can_periodic_tx_scheduler_macros.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence each operation
    cpts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the table, the walk index and the result register
    cpts_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .op          (op),
        .handle      (handle),
        .can_id      (can_id),
        .length      (length),
        .send_period (send_period),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .status      (status),
        .tx_handle   (tx_handle),
        .tx_id       (tx_id),
        .tx_length   (tx_length),
        .last        (last)
    );

    // An accepted word leaves the block busy in the next cycle
    `CPTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // A transmit request never closes an operation
    `CPTS_ASSERT_SAME(a_tx_not_last, out_valid && kind == KIND_TX, !last && status == ST_OK)
    // While idle, any pending result is the closing status word
    `CPTS_ASSERT_SAME(a_idle_pending_last, in_ready && out_valid, last && kind == KIND_STATUS)

endmodule

/* tb/sv/can_periodic_tx_scheduler_tb.sv */
// Self-checking testbench for the periodic CAN transmit scheduler.
`timescale 1ns / 100ps

module can_periodic_tx_scheduler_tb import cpts_pkg::*;;

    localparam int          DEPTH          = DEF_TABLE_DEPTH;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;   // spare op code, must answer ok
    localparam int          WATCHDOG_LIMIT = 5000;   // cycles with no handshake at all
    localparam int          DRAIN_CYCLES   = 60;     // longest remove walk plus margin
    localparam int          PHASE_WORDS    = 70;     // input words per idling phase
    localparam int          POOL_SIZE      = 24;     // handle pool, a bit larger than the table

    // One result word as the block should return it.
    typedef struct packed {
        logic                kind;
        status_t             status;
        logic [HANDLE_W-1:0] tx_handle;
        logic [ID_W-1:0]     tx_id;
        logic [LEN_W-1:0]    tx_length;
        logic                last;
    } sched_word_t;

    // Mirror of the schedule table: updates its own copy on every accepted input
    // word, queues the result words that word owes, and checks returned words
    // against the oldest one owed.
    class sched_mirror;
        logic [HANDLE_W-1:0] ent_handle   [DEPTH];
        logic [ID_W-1:0]     ent_id       [DEPTH];
        logic [LEN_W-1:0]    ent_length   [DEPTH];
        logic [TIME_W-1:0]   ent_interval [DEPTH];
        logic [TIME_W-1:0]   ent_stamp    [DEPTH];
        int unsigned         live_count = 0;
        sched_word_t         owed_q[$];

        int unsigned fail_count  = 0;
        int unsigned words_seen  = 0;
        int unsigned tx_seen     = 0;
        int unsigned full_seen   = 0;
        int unsigned peak_count  = 0;
        int unsigned op_count[4] = '{0, 0, 0, 0};

        function int slot_of(logic [HANDLE_W-1:0] h);
            for (int i = 0; i < live_count; i++)
            begin
                if (ent_handle[i] == h)
                    return i;
            end
            return -1;
        endfunction

        function void owe(logic k, status_t st, logic [HANDLE_W-1:0] h,
                          logic [ID_W-1:0] id, logic [LEN_W-1:0] len, logic fin);
            sched_word_t w;
            w.kind      = k;
            w.status    = st;
            w.tx_handle = h;
            w.tx_id     = id;
            w.tx_length = len;
            w.last      = fin;
            owed_q.push_back(w);
            if (st == ST_FULL)
                full_seen++;
        endfunction

        function void owe_status(status_t st);
            owe(KIND_STATUS, st, '0, '0, '0, 1'b1);
        endfunction

        // Advance the table for one accepted input word.
        function void note_op(logic [1:0] o, logic [HANDLE_W-1:0] h, logic [ID_W-1:0] id,
                              logic [LEN_W-1:0] len, logic [TIME_W-1:0] ivl,
                              logic [TIME_W-1:0] now);
            int                slot;
            logic [TIME_W-1:0] elapsed;
            op_count[o]++;
            case (o)
                OP_ADD:
                begin
                    if (len > MAX_DLC)
                        owe_status(ST_BAD_LEN);
                    else if (ivl == '0)
                    begin
                        // one-shot send, table untouched
                        owe(KIND_TX, ST_OK, h, id, len, 1'b0);
                        owe_status(ST_OK);
                    end
                    else if (live_count >= DEPTH)
                        owe_status(ST_FULL);   // full wins over the duplicate lookup
                    else
                    begin
                        if (slot_of(h) < 0)
                        begin
                            ent_handle[live_count]   = h;
                            ent_id[live_count]       = id;
                            ent_length[live_count]   = len;
                            ent_interval[live_count] = ivl;
                            ent_stamp[live_count]    = now;
                            live_count++;
                            if (live_count > peak_count)
                                peak_count = live_count;
                        end
                        owe_status(ST_OK);
                    end
                end
                OP_REMOVE:
                begin
                    slot = slot_of(h);
                    if (slot < 0)
                        owe_status(ST_NOT_FOUND);
                    else
                    begin
                        // close the gap, keep the order
                        for (int j = slot; j + 1 < live_count; j++)
                        begin
                            ent_handle[j]   = ent_handle[j+1];
                            ent_id[j]       = ent_id[j+1];
                            ent_length[j]   = ent_length[j+1];
                            ent_interval[j] = ent_interval[j+1];
                            ent_stamp[j]    = ent_stamp[j+1];
                        end
                        live_count--;
                        owe_status(ST_OK);
                    end
                end
                OP_TICK:
                begin
                    for (int i = 0; i < live_count; i++)
                    begin
                        elapsed = now - ent_stamp[i];   // wraps modulo 2^32
                        if (ent_interval[i] != '0 && elapsed >= ent_interval[i])
                        begin
                            owe(KIND_TX, ST_OK, ent_handle[i], ent_id[i], ent_length[i],
                                1'b0);
                            ent_stamp[i] = now;
                        end
                    end
                    owe_status(ST_OK);
                end
                default:
                    owe_status(ST_OK);
            endcase
        endfunction

        // Compare one returned word with the oldest word owed.
        function void check_word(logic k, logic [1:0] st, logic [HANDLE_W-1:0] h,
                                 logic [ID_W-1:0] id, logic [LEN_W-1:0] len, logic fin);
            sched_word_t w;
            words_seen++;
            if (owed_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected word kind %0d status %0d handle %02h id %08h",
                             $realtime, k, st, h, id);
                return;
            end
            w = owed_q.pop_front();
            if (w.kind == KIND_TX)
                tx_seen++;
            if (k !== w.kind || st !== w.status || h !== w.tx_handle || id !== w.tx_id ||
                len !== w.tx_length || fin !== w.last)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("%0t: word %0d got  k %0d st %0d h %02h id %08h len %0d last %0d",
                             $realtime, words_seen, k, st, h, id, len, fin);
                    $display("%0t: word %0d want k %0d st %0d h %02h id %08h len %0d last %0d",
                             $realtime, words_seen, w.kind, w.status, w.tx_handle, w.tx_id,
                             w.tx_length, w.last);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          op;
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     can_id;
    logic [LEN_W-1:0]    length;
    logic [TIME_W-1:0]   send_period;
    logic [TIME_W-1:0]   now_ms;
    logic                out_valid;
    logic                out_ready;
    logic                kind;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] tx_handle;
    logic [ID_W-1:0]     tx_id;
    logic [LEN_W-1:0]    tx_length;
    logic                last;

    sched_mirror         mirror;
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    int unsigned         words_sent    = 0;
    int unsigned         quiet_cycles  = 0;
    logic [TIME_W-1:0]   clock_ms      = '0;   // time the stimulus advances and hands in

    can_periodic_tx_scheduler DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .handle      (handle),
        .can_id      (can_id),
        .length      (length),
        .send_period (send_period),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .status      (status),
        .tx_handle   (tx_handle),
        .tx_id       (tx_id),
        .tx_length   (tx_length),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: drop ready at random on each falling edge, per the current phase.
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Check returned words at the rising edge and watch for a hung block.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                mirror.check_word(kind, status, tx_handle, tx_id, tx_length, last);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d words still owed",
                         quiet_cycles, mirror.owed_q.size());
                $display("can_periodic_tx_scheduler: mismatch");
                $finish;
            end
        end
    end

    // Present one input word. Enter and leave at a falling edge; valid stays
    // high on exit so a back-to-back word needs no second assignment.
    task automatic send_op(input logic [1:0] o, input logic [HANDLE_W-1:0] h,
                           input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                           input logic [TIME_W-1:0] ivl, input logic [TIME_W-1:0] now);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(negedge clk);
        end
        op          <= o;
        handle      <= h;
        can_id      <= id;
        length      <= len;
        send_period <= ivl;
        now_ms      <= now;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        mirror.note_op(o, h, id, len, ivl, now);
        words_sent++;
        @(negedge clk);
    endtask

    // Mostly short periods so ticks fire often; some zero, some huge.
    function automatic logic [TIME_W-1:0] pick_interval();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 75)
            return TIME_W'($urandom_range(1, 30));
        else if (r < 85)
            return TIME_W'($urandom());
        else if (r < 92)
            return 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 3));
        else
            return TIME_W'($urandom_range(1, 8));
    endfunction

    // Mostly handles from a small pool so adds collide and removes hit.
    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 9) == 0)
            return HANDLE_W'($urandom_range(0, 255));
        return HANDLE_W'($urandom_range(0, POOL_SIZE - 1) * 11);
    endfunction

    // Fill the table to the brim, then poke the full-table corners.
    task automatic fill_table();
        int j;
        j = 0;
        while (mirror.live_count < DEPTH)
        begin
            clock_ms += TIME_W'($urandom_range(0, 3));
            send_op(OP_ADD, HANDLE_W'(j * 11), ID_W'($urandom()),
                    LEN_W'($urandom_range(0, 8)), TIME_W'($urandom_range(1, 30)), clock_ms);
            j++;
        end
        // a handle already present still gets the full status
        send_op(OP_ADD, mirror.ent_handle[0], ID_W'($urandom()), 4'd3, 32'd5, clock_ms);
        send_op(OP_ADD, 8'hFE, ID_W'($urandom()), 4'd8, 32'd9, clock_ms);
        // one-shot send does not care about a full table
        send_op(OP_ADD, 8'hFE, ID_W'($urandom()), 4'd2, 32'd0, clock_ms);
        clock_ms += 32'd40;
        send_op(OP_TICK, 8'h00, '0, '0, '0, clock_ms);   // every entry this task added is due
    endtask

    // One random word; add_w sets how strongly the mix grows the table.
    task automatic random_op(input int unsigned add_w);
        int unsigned       r;
        logic [LEN_W-1:0]  len;
        r = $urandom_range(0, 99);
        len = ($urandom_range(0, 99) < 85) ? LEN_W'($urandom_range(0, 8))
                                           : LEN_W'($urandom_range(9, 15));
        if ($urandom_range(0, 99) < 3)
            clock_ms = TIME_W'($urandom());                 // jump, forward or back
        else
            clock_ms += TIME_W'($urandom_range(0, 12));
        if (r < add_w)
            send_op(OP_ADD, pick_handle(), ID_W'($urandom()), len, pick_interval(), clock_ms);
        else if (r < add_w + 25)
            send_op(OP_REMOVE, pick_handle(), ID_W'($urandom()), len, TIME_W'($urandom()),
                    clock_ms);
        else if (r < 95)
            send_op(OP_TICK, HANDLE_W'($urandom()), ID_W'($urandom()), len,
                    TIME_W'($urandom()), clock_ms);
        else
            send_op(OP_UNUSED, HANDLE_W'($urandom()), ID_W'($urandom()), len,
                    TIME_W'($urandom()), clock_ms);
    endtask

    initial
    begin
        int unsigned phase_start;
        int unsigned add_w;

        mirror      = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        op          = OP_ADD;
        handle      = '0;
        can_id      = '0;
        length      = '0;
        send_period = '0;
        now_ms      = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corners: empty table, spare op, bad lengths, one-shot send,
        // duplicate add, wrap of the elapsed time, removes at both ends.
        send_op(OP_TICK,   8'hA5, '0, 4'd0, 32'd0, 32'd0);
        send_op(OP_UNUSED, 8'h00, '0, 4'd0, 32'd0, 32'd0);
        send_op(OP_REMOVE, 8'h5A, '0, 4'd0, 32'd0, 32'd0);
        send_op(OP_ADD,    8'h01, 29'h0ABC_DEF0, 4'd9,  32'd10, 32'd0);
        send_op(OP_ADD,    8'h02, 29'h1FFF_FFFF, 4'd15, 32'd0,  32'd0);
        send_op(OP_ADD,    8'hFF, 29'h1FFF_FFFF, 4'd8,  32'd0,  32'd0);
        send_op(OP_ADD,    8'h00, 29'h0000_0000, 4'd0,  32'd1,  32'd0);
        send_op(OP_ADD,    8'h00, 29'h0000_0123, 4'd5,  32'd7,  32'd3);
        send_op(OP_ADD,    8'hFF, 29'h1FFF_FFFF, 4'd8,  32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_op(OP_ADD,    8'h3C, 29'h1555_5555, 4'd4,  32'd20, 32'd5);
        send_op(OP_TICK,   8'h00, '0, 4'd0, 32'd0, 32'd1);
        send_op(OP_TICK,   8'h00, '0, 4'd0, 32'd0, 32'd1);
        send_op(OP_TICK,   8'h00, '0, 4'd0, 32'd0, 32'hFFFF_FFEF);
        send_op(OP_REMOVE, 8'h00, '0, 4'd0, 32'd0, 32'd0);
        send_op(OP_REMOVE, 8'h3C, '0, 4'd0, 32'd0, 32'd0);
        send_op(OP_REMOVE, 8'h00, '0, 4'd0, 32'd0, 32'd0);
        send_op(OP_ADD,    8'hAA, 29'h0AAA_AAAA, 4'd8,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_TICK,   8'hFF, 29'h1FFF_FFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_UNUSED, 8'hFF, 29'h1FFF_FFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_REMOVE, 8'hFF, '0, 4'd0, 32'd0, 32'd0);
        send_op(OP_REMOVE, 8'hAA, '0, 4'd0, 32'd0, 32'd0);

        // Random phases: receiver-heavy idling, sender-heavy idling, then none.
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 57;
                end
                1:
                begin
                    send_idle_pct = 57;
                    recv_idle_pct = 35;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p == 1)
                clock_ms = 32'hFFFF_FF00;   // run this phase across the time wrap
            phase_start = words_sent;
            add_w = 55;
            fill_table();
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                // every 16 words, pick at random between growing and draining the table
                if ((words_sent % 16) == 0)
                    add_w = ($urandom_range(0, 1) != 0) ? 55 : 20;
                random_op(add_w);
            end
        end

        in_valid <= 1'b0;

        // Drain: wait for every owed word, then give stray words time to show.
        while (mirror.owed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d words: %0d adds, %0d removes, %0d ticks, %0d spare-op",
                 words_sent, mirror.op_count[OP_ADD], mirror.op_count[OP_REMOVE],
                 mirror.op_count[OP_TICK], mirror.op_count[OP_UNUSED]);
        $display("checked %0d result words, %0d transmit requests, %0d table-full, peak %0d",
                 mirror.words_seen, mirror.tx_seen, mirror.full_seen, mirror.peak_count);
        if (mirror.fail_count == 0 && mirror.owed_q.size() == 0)
            $display("can_periodic_tx_scheduler: match");
        else
            $display("can_periodic_tx_scheduler: mismatch");
        $finish;
    end

endmodule
